@@ rtl/hsie_pkg.sv @@
// Shared types and constants for the hashed-state instruction executor.
`timescale 1ns / 1ps
`default_nettype none

package hsie_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  reg_idx_t;

  localparam int unsigned NUM_REGS = 16;

  localparam logic [3:0] MODE_ALU    = 4'd0;
  localparam logic [3:0] MODE_CMP    = 4'd2;
  localparam logic [3:0] MODE_BIND   = 4'd3;
  localparam logic [3:0] MODE_STATE  = 4'd4;
  localparam logic [3:0] MODE_PROOF  = 4'd6;
  localparam logic [3:0] MODE_COMMIT = 4'd7;
  localparam logic [3:0] MODE_HALT   = 4'd15;

  localparam logic [3:0] ALU_ADD     = 4'd0;
  localparam logic [3:0] ALU_SUB     = 4'd1;
  localparam logic [3:0] ALU_AND     = 4'd2;
  localparam logic [3:0] ALU_OR      = 4'd3;
  localparam logic [3:0] ALU_XOR     = 4'd4;
  localparam logic [3:0] ALU_NOT     = 4'd5;
  localparam logic [3:0] ALU_SHL     = 4'd6;
  localparam logic [3:0] ALU_SHR     = 4'd7;
  localparam logic [3:0] ALU_ROTL    = 4'd8;
  localparam logic [3:0] ALU_ROTR    = 4'd9;
  localparam logic [3:0] ALU_AND_ALT = 4'd10;
  localparam logic [3:0] ALU_XOR_ALT = 4'd11;
  localparam logic [3:0] ALU_BIT     = 4'd12;

  localparam logic [3:0] SOP_SEED      = 4'd0;
  localparam logic [3:0] SOP_SPRING    = 4'd1;
  localparam logic [3:0] SOP_PROPAGATE = 4'd2;
  localparam logic [3:0] SOP_FORK      = 4'd3;
  localparam logic [3:0] SOP_JOIN      = 4'd4;
  localparam logic [3:0] SOP_ROLLBACK  = 4'd5;
  localparam logic [3:0] SOP_SNAPSHOT  = 4'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_HALT    = 2'd2;

  localparam word_t MIX_K1 = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_K2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HASH,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic     en;
    reg_idx_t addr;
    word_t    data;
  } rf_wr_t;

endpackage

`default_nettype wire

@@ rtl/hsie_regfile.sv @@
// Sixteen-entry register file memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module hsie_regfile
  import hsie_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire rf_wr_t   wr,
  input  wire reg_idx_t raddr_a,
  input  wire reg_idx_t raddr_b,
  output word_t         rdata_a,
  output word_t         rdata_b
);

  word_t                mem [NUM_REGS];
  logic [NUM_REGS-1:0]  vld;
  word_t                rd_a;
  word_t                rd_b;
  logic                 rd_a_ok;
  logic                 rd_b_ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_a_ok <= 1'b0;
      rd_b_ok <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_a_ok <= vld[raddr_a];
      rd_b_ok <= vld[raddr_b];
    end
  end

  assign rdata_a = rd_a_ok ? rd_a : '0;
  assign rdata_b = rd_b_ok ? rd_b : '0;

endmodule

`default_nettype wire

@@ rtl/hsie_mix.sv @@
// Iterative 64-bit mix finalizer built on one shared 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module hsie_mix
  import hsie_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t x,
  output logic       done,
  output word_t      y
);

  logic        busy;
  logic        round;
  logic [1:0]  part;
  word_t       opnd;
  word_t       acc;
  word_t       k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  word_t       prod;
  word_t       sum;

  assign k     = round ? MIX_K2 : MIX_K1;
  assign mul_a = (part == 2'd1) ? opnd[63:32] : opnd[31:0];
  assign mul_b = (part == 2'd2) ? k[63:32] : k[31:0];
  assign prod  = {32'h0, mul_a} * {32'h0, mul_b};
  assign sum   = acc + {prod[31:0], 32'h0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= 1'b0;
      part  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opnd  <= x ^ (x >> 30);
        round <= 1'b0;
        part  <= 2'd0;
        busy  <= 1'b1;
      end else if (busy) begin
        case (part)
          2'd0: begin
            acc  <= prod;
            part <= 2'd1;
          end
          2'd1: begin
            acc  <= sum;
            part <= 2'd2;
          end
          2'd2: begin
            part <= 2'd0;
            if (!round) begin
              opnd  <= sum ^ (sum >> 27);
              round <= 1'b1;
            end else begin
              y    <= sum ^ (sum >> 31);
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: part <= 2'd0;
        endcase
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("mix done while still busy");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("mix restarted while busy");

endmodule

`default_nettype wire

@@ rtl/hashed_state_instruction_executor.sv @@
// Top level: instruction sequencer, state registers and result register.
// ALU, compare, bind, simple state ops, commit, halt and illegal go from the
// command beat through the execute and done states to the result beat; seed,
// spring, propagate, fork and proof also wait in the hash state for the six
// multiply steps of the mix unit. One instruction at a time; the next command
// beat is taken once the result is registered. Reset clears the seed, chain,
// history and semantic registers to zero; the regfile reads zero until written.
`timescale 1ns / 1ps
`default_nettype none

module hashed_state_instruction_executor
  import hsie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [3:0]  mode,
  input  wire logic [3:0]  sub_op,
  input  wire logic [3:0]  dest_reg,
  input  wire logic [3:0]  first_src_reg,
  input  wire logic [3:0]  second_src_reg,
  input  wire logic        write_flag,
  input  wire logic        commit_flag,
  input  wire logic [15:0] shift_amount,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [63:0]      result_value,
  output logic [1:0]       exec_status,
  output logic [63:0]      semantic_value
);

  fsm_state_t state;
  fsm_state_t state_next;

  logic [3:0] mode_q;
  logic [3:0] sub_q;
  reg_idx_t   dest_q;
  logic       wr_q;
  logic       cm_q;
  logic [5:0] sh_q;

  word_t      rd_a;
  word_t      rd_b;
  rf_wr_t     rf_wr;

  word_t      seed_reg;
  word_t      chain_state;
  word_t      history_reg;
  word_t      semantic_reg;

  word_t      res_q;
  logic [1:0] status_q;

  word_t      alu_res;
  word_t      exec_res;
  logic [1:0] exec_stat;
  logic       needs_hash;
  word_t      mix_x;
  logic       mix_start;
  logic       mix_done;
  word_t      mix_y;

  logic       cmd_beat;
  logic       out_free;
  logic       finish;
  logic       ok;

  assign cmd_beat = cmd_valid && !cmd_stall;
  assign out_free = !res_valid || !res_stall;
  assign ok       = (status_q == ST_OK);

  hsie_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (rf_wr),
    .raddr_a (first_src_reg),
    .raddr_b (second_src_reg),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  hsie_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .x     (mix_x),
    .done  (mix_done),
    .y     (mix_y)
  );

  always_ff @(posedge clk) begin
    if (cmd_beat) begin
      mode_q <= mode;
      sub_q  <= sub_op;
      dest_q <= dest_reg;
      wr_q   <= write_flag;
      cm_q   <= commit_flag;
      sh_q   <= shift_amount[5:0];
    end
  end

  always_comb begin
    case (sub_q) inside
      ALU_ADD:              alu_res = rd_a + rd_b;
      ALU_SUB:              alu_res = rd_a - rd_b;
      ALU_AND, ALU_AND_ALT: alu_res = rd_a & rd_b;
      ALU_OR:               alu_res = rd_a | rd_b;
      ALU_XOR, ALU_XOR_ALT: alu_res = rd_a ^ rd_b;
      ALU_NOT:              alu_res = ~rd_a;
      ALU_SHL:              alu_res = rd_a << sh_q;
      ALU_SHR:              alu_res = rd_a >> sh_q;
      ALU_ROTL:             alu_res = (rd_a << sh_q) | (rd_a >> (7'd64 - {1'b0, sh_q}));
      ALU_ROTR:             alu_res = (rd_a >> sh_q) | (rd_a << (7'd64 - {1'b0, sh_q}));
      ALU_BIT:              alu_res = {63'h0, rd_a[sh_q]};
      default:              alu_res = '0;
    endcase
  end

  always_comb begin
    exec_res   = '0;
    exec_stat  = ST_OK;
    needs_hash = 1'b0;
    mix_x      = rd_a;
    unique case (mode_q)
      MODE_ALU:  exec_res = alu_res;
      MODE_CMP:  exec_res = {63'h0, rd_a == rd_b};
      MODE_BIND: exec_res = rd_a ^ rd_b;
      MODE_STATE: begin
        unique case (sub_q)
          SOP_SEED: needs_hash = 1'b1;
          SOP_SPRING: begin
            needs_hash = 1'b1;
            mix_x      = chain_state ^ {seed_reg[46:0], seed_reg[63:47]};
          end
          SOP_PROPAGATE, SOP_FORK: begin
            needs_hash = 1'b1;
            mix_x      = chain_state ^ {rd_a[46:0], rd_a[63:47]};
          end
          SOP_JOIN:     exec_res  = chain_state ^ rd_a;
          SOP_ROLLBACK: exec_res  = history_reg;
          SOP_SNAPSHOT: exec_res  = chain_state;
          default:      exec_stat = ST_ILLEGAL;
        endcase
      end
      MODE_PROOF: begin
        needs_hash = 1'b1;
        mix_x      = rd_a ^ rd_b;
      end
      MODE_COMMIT: exec_res  = chain_state;
      MODE_HALT:   exec_stat = ST_HALT;
      default:     exec_stat = ST_ILLEGAL;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_beat) state_next = S_EXEC;
      S_EXEC: state_next = needs_hash ? S_HASH : S_DONE;
      S_HASH: if (mix_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall  = (state != S_IDLE);
    mix_start  = (state == S_EXEC) && needs_hash;
    finish     = (state == S_DONE) && out_free;
    rf_wr.en   = finish && ok && wr_q;
    rf_wr.addr = dest_q;
    rf_wr.data = res_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_q    <= exec_res;
      status_q <= exec_stat;
    end else if (state == S_HASH && mix_done) begin
      res_q <= mix_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg     <= '0;
      chain_state  <= '0;
      history_reg  <= '0;
      semantic_reg <= '0;
    end else if (finish && ok) begin
      if (cm_q) begin
        semantic_reg <= res_q;
      end
      unique case (mode_q)
        MODE_STATE: begin
          unique case (sub_q)
            SOP_SEED: seed_reg <= res_q;
            SOP_SPRING, SOP_PROPAGATE, SOP_JOIN, SOP_ROLLBACK: chain_state <= res_q;
            SOP_FORK: begin
              history_reg <= chain_state;
              chain_state <= res_q;
            end
            SOP_SNAPSHOT: history_reg <= chain_state;
            default: ;
          endcase
        end
        MODE_COMMIT: history_reg <= chain_state;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_value   <= ok ? res_q : '0;
      exec_status    <= status_q;
      semantic_value <= (ok && cm_q) ? res_q : semantic_reg;
    end
  end

  a_mix_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> state == S_HASH)
    else $error("mix result outside hash wait");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result beat without finished instruction");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && exec_status != ST_OK |-> result_value == '0)
    else $error("nonzero result on halt or illegal");

  a_exec_after_beat: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> $past(cmd_valid && !cmd_stall))
    else $error("execute without command beat");

endmodule

`default_nettype wire

@@ bench/hashed_state_instruction_executor_tb.sv @@
// Self-checking testbench for the hashed-state instruction executor.
`timescale 1ns / 1ps

module hashed_state_instruction_executor_tb
  import hsie_pkg::*;
();

  localparam logic [3:0] MODE_RSVD_LO = 4'd1;
  localparam logic [3:0] MODE_RSVD_HI = 4'd14;
  localparam logic [3:0] ALU_UNDEF    = 4'd13;
  localparam logic [3:0] SOP_UNDEF    = 4'd7;
  localparam logic [3:0] SUB_NONE     = 4'd0;
  localparam int N_RANDOM    = 1550;
  localparam int PAUSE_AT    = 1000;
  localparam int CALM_LO     = 700;
  localparam int CALM_HI     = 900;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  sub_op;
    logic [3:0]  dst;
    logic [3:0]  sa;
    logic [3:0]  sb;
    logic        wr;
    logic        cm;
    logic [15:0] imm;
  } insn_t;

  typedef struct packed {
    word_t      res;
    logic [1:0] st;
    word_t      sem;
  } outcome_t;

  typedef struct {
    insn_t      insn;
    bit         fixed;
    word_t      fixed_res;
    logic [1:0] fixed_st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [3:0]  mode = '0;
  logic [3:0]  sub_op = '0;
  logic [3:0]  dest_reg = '0;
  logic [3:0]  first_src_reg = '0;
  logic [3:0]  second_src_reg = '0;
  logic        write_flag = 1'b0;
  logic        commit_flag = 1'b0;
  logic [15:0] shift_amount = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [63:0] result_value;
  logic [1:0]  exec_status;
  logic [63:0] semantic_value;

  word_t regs [16];
  word_t seed_word, chain_word, history_word, proof_word, semantic_word;

  outcome_t pending_outcomes[$];
  row_t     directed_rows[$];
  int       failures = 0;
  int       results_seen = 0;
  int       hold_left = 0;
  int       stall_left = 0;
  bit       held = 1'b0;

  hashed_state_instruction_executor dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .mode           (mode),
    .sub_op         (sub_op),
    .dest_reg       (dest_reg),
    .first_src_reg  (first_src_reg),
    .second_src_reg (second_src_reg),
    .write_flag     (write_flag),
    .commit_flag    (commit_flag),
    .shift_amount   (shift_amount),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .result_value   (result_value),
    .exec_status    (exec_status),
    .semantic_value (semantic_value)
  );

  always #5 clk = ~clk;

  function automatic word_t rotate_left(input word_t x, input int unsigned n);
    int unsigned k;
    k = n & 63;
    if (k == 0) return x;
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic word_t finalize(input word_t v);
    word_t x;
    x = v;
    x = x ^ (x >> 30);
    x = x * MIX_K1;
    x = x ^ (x >> 27);
    x = x * MIX_K2;
    x = x ^ (x >> 31);
    return x;
  endfunction

  function automatic word_t fold(input word_t x, input word_t y);
    return finalize(x ^ rotate_left(y, 17));
  endfunction

  function automatic void execute_insn(input insn_t i, output outcome_t o);
    word_t       a, b, r;
    logic [1:0]  st;
    int unsigned sh;
    a  = regs[i.sa];
    b  = regs[i.sb];
    r  = '0;
    st = ST_OK;
    sh = {26'd0, i.imm[5:0]};
    case (i.mode)
      MODE_ALU: begin
        case (i.sub_op)
          ALU_ADD:     r = a + b;
          ALU_SUB:     r = a - b;
          ALU_AND:     r = a & b;
          ALU_OR:      r = a | b;
          ALU_XOR:     r = a ^ b;
          ALU_NOT:     r = ~a;
          ALU_SHL:     r = a << sh;
          ALU_SHR:     r = a >> sh;
          ALU_ROTL:    r = rotate_left(a, sh);
          ALU_ROTR:    r = rotate_left(a, 64 - sh);
          ALU_AND_ALT: r = a & b;
          ALU_XOR_ALT: r = a ^ b;
          ALU_BIT:     r = (a >> sh) & 64'd1;
          default:     r = '0;
        endcase
      end
      MODE_CMP:  r = (a == b) ? 64'd1 : 64'd0;
      MODE_BIND: r = a ^ b;
      MODE_STATE: begin
        case (i.sub_op)
          SOP_SEED: begin
            seed_word = finalize(a);
            r = seed_word;
          end
          SOP_SPRING: begin
            chain_word = fold(chain_word, seed_word);
            r = chain_word;
          end
          SOP_PROPAGATE: begin
            chain_word = fold(chain_word, a);
            r = chain_word;
          end
          SOP_FORK: begin
            history_word = chain_word;
            chain_word = fold(chain_word, a);
            r = chain_word;
          end
          SOP_JOIN: begin
            chain_word = chain_word ^ a;
            r = chain_word;
          end
          SOP_ROLLBACK: begin
            chain_word = history_word;
            r = chain_word;
          end
          SOP_SNAPSHOT: begin
            history_word = chain_word;
            r = history_word;
          end
          default: st = ST_ILLEGAL;
        endcase
      end
      MODE_PROOF: begin
        proof_word = finalize(a ^ b);
        r = proof_word;
      end
      MODE_COMMIT: begin
        history_word = chain_word;
        r = chain_word;
      end
      MODE_HALT: st = ST_HALT;
      default:   st = ST_ILLEGAL;
    endcase
    if (st == ST_OK) begin
      if (i.wr) regs[i.dst] = r;
      if (i.cm) semantic_word = r;
    end else begin
      r = '0;
    end
    o.res = r;
    o.st  = st;
    o.sem = semantic_word;
  endfunction

  task automatic add_row(input logic [3:0] m, s, d, a, b, input logic w, c,
                         input logic [15:0] imm, input bit fixed = 1'b0,
                         input word_t fres = '0, input logic [1:0] fst = ST_OK);
    row_t r;
    r.insn.mode   = m;
    r.insn.sub_op = s;
    r.insn.dst    = d;
    r.insn.sa     = a;
    r.insn.sb     = b;
    r.insn.wr     = w;
    r.insn.cm     = c;
    r.insn.imm    = imm;
    r.fixed       = fixed;
    r.fixed_res   = fres;
    r.fixed_st    = fst;
    directed_rows.push_back(r);
  endtask

  function automatic insn_t random_insn();
    insn_t       i;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    i.sub_op = 4'($urandom_range(0, 15));
    i.dst    = 4'($urandom_range(0, 15));
    i.sa     = 4'($urandom_range(0, 15));
    i.sb     = 4'($urandom_range(0, 15));
    i.wr     = ($urandom_range(0, 99) < 80);
    i.cm     = ($urandom_range(0, 99) < 25);
    i.imm    = 16'($urandom_range(0, 65535));
    if (pick < 40) begin
      i.mode = MODE_ALU;
    end else if (pick < 48) begin
      i.mode = MODE_CMP;
      if ($urandom_range(0, 99) < 30) i.sb = i.sa;
    end else if (pick < 55) begin
      i.mode = MODE_BIND;
    end else if (pick < 80) begin
      i.mode = MODE_STATE;
      if ($urandom_range(0, 99) < 90) i.sub_op = 4'($urandom_range(SOP_SEED, SOP_SNAPSHOT));
      else i.sub_op = 4'($urandom_range(SOP_UNDEF, 15));
    end else if (pick < 87) begin
      i.mode = MODE_PROOF;
    end else if (pick < 92) begin
      i.mode = MODE_COMMIT;
    end else if (pick < 96) begin
      do begin
        i.mode = 4'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
      end while (i.mode == MODE_CMP || i.mode == MODE_BIND || i.mode == MODE_STATE ||
                 i.mode == MODE_PROOF || i.mode == MODE_COMMIT);
    end else begin
      i.mode = MODE_HALT;
    end
    return i;
  endfunction

  task automatic issue(input insn_t i);
    mode           <= i.mode;
    sub_op         <= i.sub_op;
    dest_reg       <= i.dst;
    first_src_reg  <= i.sa;
    second_src_reg <= i.sb;
    write_flag     <= i.wr;
    commit_flag    <= i.cm;
    shift_amount   <= i.imm;
    cmd_valid      <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input bit calm);
    int unsigned pick, gap;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (!calm) begin
      if (pick >= 93) gap = $urandom_range(8, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    outcome_t    want;
    int unsigned pick;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          note_failure($sformatf("result beat %0d with nothing expected", results_seen));
        end else begin
          want = pending_outcomes.pop_front();
          if (result_value !== want.res)
            note_failure($sformatf("beat %0d result_value exp %h got %h",
                                   results_seen, want.res, result_value));
          if (exec_status !== want.st)
            note_failure($sformatf("beat %0d exec_status exp %0d got %0d",
                                   results_seen, want.st, exec_status));
          if (semantic_value !== want.sem)
            note_failure($sformatf("beat %0d semantic_value exp %h got %h",
                                   results_seen, want.sem, semantic_value));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (results_seen == HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        res_stall <= 1'b1;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        res_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          res_stall <= 1'b0;
        end else if (pick < 95) begin
          stall_left = $urandom_range(0, 2);
          res_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(8, 40);
          res_stall <= 1'b1;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    outcome_t o;
    insn_t    i;
    for (int r = 0; r < 16; r++) regs[r] = '0;
    seed_word     = '0;
    chain_word    = '0;
    history_word  = '0;
    proof_word    = '0;
    semantic_word = '0;

    add_row(MODE_ALU, ALU_NOT, 1, 0, 0, 1'b1, 1'b1, 16'h0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(MODE_ALU, ALU_ADD, 2, 1, 1, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_SEED, 3, 2, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_SUB, 4, 0, 1, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_AND, 5, 3, 2, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_OR, 6, 3, 4, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_XOR, 7, 3, 1, 1'b1, 1'b1, 16'h0000);
    add_row(MODE_ALU, ALU_SHL, 8, 3, 0, 1'b1, 1'b0, 16'hFFFF);
    add_row(MODE_ALU, ALU_SHR, 9, 1, 0, 1'b1, 1'b0, 16'h003F, 1'b1, 64'd1);
    add_row(MODE_ALU, ALU_ROTL, 10, 3, 0, 1'b1, 1'b0, 16'h0040);
    add_row(MODE_ALU, ALU_ROTR, 11, 3, 0, 1'b1, 1'b0, 16'h8011);
    add_row(MODE_ALU, ALU_AND_ALT, 12, 3, 7, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_XOR_ALT, 13, 7, 3, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_ALU, ALU_BIT, 14, 1, 0, 1'b1, 1'b0, 16'hFFC0, 1'b1, 64'd1);
    add_row(MODE_ALU, ALU_UNDEF, 15, 1, 1, 1'b1, 1'b1, 16'h1234, 1'b1, 64'd0);
    add_row(MODE_CMP, SUB_NONE, 14, 3, 3, 1'b1, 1'b0, 16'h0000, 1'b1, 64'd1);
    add_row(MODE_BIND, SUB_NONE, 15, 3, 7, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_SPRING, 6, 0, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_PROPAGATE, 7, 3, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_FORK, 8, 5, 0, 1'b1, 1'b1, 16'h0000);
    add_row(MODE_STATE, SOP_JOIN, 9, 1, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_ROLLBACK, 10, 0, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_SNAPSHOT, 11, 0, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_STATE, SOP_UNDEF, 12, 3, 3, 1'b1, 1'b1, 16'hFFFF, 1'b1, 64'd0, ST_ILLEGAL);
    add_row(MODE_PROOF, SUB_NONE, 13, 3, 4, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_COMMIT, SUB_NONE, 0, 0, 0, 1'b1, 1'b0, 16'h0000);
    add_row(MODE_RSVD_LO, SUB_NONE, 1, 2, 3, 1'b1, 1'b1, 16'h0000, 1'b1, 64'd0, ST_ILLEGAL);
    add_row(MODE_HALT, 4'hF, 2, 3, 4, 1'b1, 1'b1, 16'hFFFF, 1'b1, 64'd0, ST_HALT);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      issue(directed_rows[k].insn);
      execute_insn(directed_rows[k].insn, o);
      if (directed_rows[k].fixed) begin
        o.res = directed_rows[k].fixed_res;
        o.st  = directed_rows[k].fixed_st;
      end
      pending_outcomes.push_back(o);
      pause_sender(1'b0);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      i = random_insn();
      issue(i);
      execute_insn(i, o);
      pending_outcomes.push_back(o);
      if (k == PAUSE_AT) begin
        cmd_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
      end else begin
        pause_sender(k >= CALM_LO && k < CALM_HI);
      end
    end

    cmd_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hsie_pkg.sv
rtl/hsie_regfile.sv
rtl/hsie_mix.sv
rtl/hashed_state_instruction_executor.sv
bench/hashed_state_instruction_executor_tb.sv
